// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared types and constants for the double-ended queue core: operation and
// status codes, and the control word that drives a chain of storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Width of one stored value and of the reported fill count.
   localparam int DataW = 32;
   localparam int FillW = 5;

   // Operation requested by one input word.
   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_POP_FRONT  = 2'd1,
      ACT_PUSH_BACK  = 2'd2,
      ACT_POP_BACK   = 2'd3
   } action_type;

   // Outcome reported with each result word.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // What every cell of one chain does in a cycle.
   typedef enum logic [1:0] {
      CH_HOLD   = 2'd0,
      CH_INSERT = 2'd1,
      CH_REMOVE = 2'd2,
      CH_LOAD   = 2'd3
   } chain_op_type;

   // Control broadcast to all cells of one chain.
   typedef struct packed {
      chain_op_type             op;
      logic signed [DataW-1:0]  data;
   } chain_ctl_type;

endpackage

// ===== design/deq_req_if.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel carrying one operation word into the queue.
// ----------------------------------------------------------------------------
interface deq_req_if;

   logic                              valid;
   logic                              ready;
   deq_pkg::action_type               action;
   logic signed [deq_pkg::DataW-1:0]  data_in;

   modport source (output valid, output action, output data_in, input ready);
   modport sink   (input valid, input action, input data_in, output ready);

endinterface

// ===== design/deq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue response channel
// Valid/ready channel carrying one result word out of the queue.
// ----------------------------------------------------------------------------
interface deq_rsp_if;

   logic                              valid;
   logic                              ready;
   logic signed [deq_pkg::DataW-1:0]  data_out;
   deq_pkg::status_type               status;
   logic [deq_pkg::FillW-1:0]         fill_count;

   modport source (output valid, output data_out, output status, output fill_count,
                   input ready);
   modport sink   (input valid, input data_out, input status, input fill_count,
                   output ready);

endinterface

// ===== design/deq_cell.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue storage cell
// One entry of a storage chain. It takes the value of its lower neighbor on
// an insert, of its upper neighbor on a remove, or the pushed value when the
// chain loads at its position.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                              clock,
   input  deq_pkg::chain_ctl_type            ctl,
   input  logic                              load_hit,
   input  logic signed [deq_pkg::DataW-1:0]  lower_data,
   input  logic signed [deq_pkg::DataW-1:0]  upper_data,
   output logic signed [deq_pkg::DataW-1:0]  cell_data
);

   logic signed [deq_pkg::DataW-1:0] data_ff;
   logic signed [deq_pkg::DataW-1:0] data_in;

   // Select the next value of this entry.
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         deq_pkg::CH_HOLD:   data_in = data_ff;
         deq_pkg::CH_INSERT: data_in = lower_data;
         deq_pkg::CH_REMOVE: data_in = upper_data;
         deq_pkg::CH_LOAD:   data_in = load_hit ? ctl.data : data_ff;
         default:            data_in = data_ff;
      endcase
   end

   // Stored value; its content is meaningless until written.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

// ===== design/deq_chain.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue storage chain
// A row of cells that keeps the queue in order from one end, so that the
// entry at that end always sits in cell zero. Inserting shifts the row up by
// one cell, removing shifts it down, and loading writes the cell whose
// position equals the current entry count.
// ----------------------------------------------------------------------------
module deq_chain #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  deq_pkg::chain_ctl_type            ctl,
   input  logic [$clog2(DEPTH+1)-1:0]        load_pos,
   output logic signed [deq_pkg::DataW-1:0]  head_data
);

   localparam int CountW = $clog2(DEPTH + 1);

   logic signed [deq_pkg::DataW-1:0] cell_data [DEPTH];

   // Build the row; each cell sees its two neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [deq_pkg::DataW-1:0] lower_data;
      logic signed [deq_pkg::DataW-1:0] upper_data;
      logic                             load_hit;

      if (i == 0) begin : g_first
         assign lower_data = ctl.data;
      end else begin : g_inner_lower
         assign lower_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper_data = cell_data[i];
      end else begin : g_inner_upper
         assign upper_data = cell_data[i+1];
      end

      assign load_hit = (load_pos == CountW'(i));

      deq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load_hit   (load_hit),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .cell_data  (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

// ===== design/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded double-ended queue of signed 32-bit values with push and pop at
// both ends, one result word per request word.
// ----------------------------------------------------------------------------
// The queue accepts one request word per clock cycle while results drain and
// returns its result word from an output register; a new request is taken even
// while the previous result waits, as long as the output register frees up
// in the same cycle. Storage is two rows of DEPTH cells: one row keeps the
// entries ordered from the front, the other from the back, so both ends are
// always in cell zero of a row and every operation finishes in the cycle it
// is accepted. A push onto a full queue or a pop from an empty one is refused
// with a status code and leaves the queue unchanged. No clearing pass is
// needed after reset. The reported fill count is the entry count after the
// operation, kept to its five bits.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   deq_req_if.sink     req_bus,
   deq_rsp_if.source   rsp_bus
);

   localparam int CountW = $clog2(DEPTH + 1);

   // Queue occupancy.
   logic [CountW-1:0]                 count_ff;
   logic [CountW-1:0]                 count_in;

   // Result word register.
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [deq_pkg::DataW-1:0]  rsp_data_ff;
   logic signed [deq_pkg::DataW-1:0]  rsp_data_in;
   deq_pkg::status_type               rsp_status_ff;
   deq_pkg::status_type               rsp_status_in;
   logic [deq_pkg::FillW-1:0]         rsp_fill_ff;
   logic [deq_pkg::FillW-1:0]         rsp_fill_in;

   // Chain control and heads.
   deq_pkg::chain_ctl_type            front_ctl;
   deq_pkg::chain_ctl_type            back_ctl;
   logic signed [deq_pkg::DataW-1:0]  front_head;
   logic signed [deq_pkg::DataW-1:0]  back_head;

   logic                              accept;
   logic                              full;
   logic                              empty;
   logic [31:0]                       count_wide;

   // A request is taken when the result register is free or being drained.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign full  = (count_ff == CountW'(DEPTH));
   assign empty = (count_ff == '0);

   // Decode the operation into chain moves, the new count and the result.
   always_comb begin
      front_ctl.op   = deq_pkg::CH_HOLD;
      front_ctl.data = req_bus.data_in;
      back_ctl.op    = deq_pkg::CH_HOLD;
      back_ctl.data  = req_bus.data_in;
      count_in       = count_ff;
      rsp_data_in    = '0;
      rsp_status_in  = deq_pkg::ST_OK;
      if (accept) begin
         case (req_bus.action)
            deq_pkg::ACT_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = deq_pkg::ST_FULL;
               end else begin
                  front_ctl.op = deq_pkg::CH_INSERT;
                  back_ctl.op  = deq_pkg::CH_LOAD;
                  count_in     = count_ff + 1'b1;
               end
            end
            deq_pkg::ACT_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = deq_pkg::ST_FULL;
               end else begin
                  front_ctl.op = deq_pkg::CH_LOAD;
                  back_ctl.op  = deq_pkg::CH_INSERT;
                  count_in     = count_ff + 1'b1;
               end
            end
            deq_pkg::ACT_POP_FRONT: begin
               if (empty) begin
                  rsp_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  front_ctl.op = deq_pkg::CH_REMOVE;
                  rsp_data_in  = front_head;
                  count_in     = count_ff - 1'b1;
               end
            end
            deq_pkg::ACT_POP_BACK: begin
               if (empty) begin
                  rsp_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  back_ctl.op = deq_pkg::CH_REMOVE;
                  rsp_data_in = back_head;
                  count_in    = count_ff - 1'b1;
               end
            end
            default: begin
               rsp_status_in = deq_pkg::ST_OK;
            end
         endcase
      end
   end

   // Fill count reported with the word, kept to its field width.
   assign count_wide  = 32'(count_in);
   assign rsp_fill_in = count_wide[deq_pkg::FillW-1:0];

   // The output register loads on accept and empties when drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
      end
   end

   // Row ordered from the front of the queue.
   deq_chain #(
      .DEPTH (DEPTH)
   ) u_front_chain (
      .clock     (clock),
      .ctl       (front_ctl),
      .load_pos  (count_ff),
      .head_data (front_head)
   );

   // Row ordered from the back of the queue.
   deq_chain #(
      .DEPTH (DEPTH)
   ) u_back_chain (
      .clock     (clock),
      .ctl       (back_ctl),
      .load_pos  (count_ff),
      .head_data (back_head)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.data_out   = rsp_data_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.fill_count = rsp_fill_ff;

endmodule

// ===== dv/deq_mirror.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue mirror
// Watches the request and response channels of the queue core, keeps its own
// copy of the queue contents, works out the result word of every accepted
// request and compares each accepted response field by field, in order.
// ----------------------------------------------------------------------------
module deq_mirror #(
   parameter int Depth = 16
) (
   input  logic         clock,
   input  logic         reset,
   deq_req_if           req_bus,
   deq_rsp_if           rsp_bus,
   output int unsigned  fail_count,
   output int unsigned  pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   // One predicted result word.
   typedef struct {
      logic signed [DataW-1:0]  data_out;
      status_type               status;
      logic [FillW-1:0]         fill_count;
   } reply_type;

   // Mirrored queue: ring of slots addressed by head position and count.
   // The counters are two-state and start at zero.
   logic signed [DataW-1:0]  slots [Depth];
   int unsigned              head_pos;
   int unsigned              held;
   reply_type                pending_replies [$];

   // Applies one operation to the mirrored queue and returns its result word.
   function automatic reply_type apply_to_mirror(input action_type act,
                                                 input logic signed [DataW-1:0] value);
      reply_type r;
      r.data_out = '0;
      r.status   = ST_OK;
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (held >= Depth) begin
               r.status = ST_FULL;
            end else if (act == ACT_PUSH_FRONT) begin
               head_pos        = (head_pos + Depth - 1) % Depth;
               slots[head_pos] = value;
               held++;
            end else begin
               slots[(head_pos + held) % Depth] = value;
               held++;
            end
         end
         default: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else if (act == ACT_POP_FRONT) begin
               r.data_out = slots[head_pos];
               head_pos   = (head_pos + 1) % Depth;
               held--;
            end else begin
               r.data_out = slots[(head_pos + held - 1) % Depth];
               held--;
            end
         end
      endcase
      r.fill_count = FillW'(held);
      return r;
   endfunction

   // Compare responses first: a response taken at this edge always belongs to
   // a request accepted at an earlier edge.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         head_pos = 0;
         held     = 0;
         pending_replies.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_replies.size() == 0) begin
               $error("response word arrived with no request waiting for it");
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_bus.data_out !== want.data_out) begin
                  $error("data_out mismatch: expected %0d, actual %0d",
                         want.data_out, rsp_bus.data_out);
                  fail_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status mismatch: expected %s, actual %s",
                         want.status.name(), rsp_bus.status.name());
                  fail_count++;
               end
               if (rsp_bus.fill_count !== want.fill_count) begin
                  $error("fill_count mismatch: expected %0d, actual %0d",
                         want.fill_count, rsp_bus.fill_count);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_replies.push_back(apply_to_mirror(req_bus.action, req_bus.data_in));
         end
      end
      pending_count = pending_replies.size();
   end

endmodule

// ===== dv/double_ended_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core test
// Drives push and pop words at both ends of the queue: a directed pass over
// the empty and full corners and the value extremes, then long random runs
// that lean toward pushing or popping so the queue swings between empty and
// full. Both channels idle and stall at random; the mirror checks results.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int Depth       = 16;
   localparam int RandomWords = 2000;
   localparam int StallLimit  = 5000;
   localparam int DrainCycles = 8;

   logic         clock;
   logic         reset;
   logic         calm;
   int unsigned  fail_count;
   int unsigned  pending_count;
   int unsigned  quiet_cycles;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue_core #(.DEPTH(Depth)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   deq_mirror #(.Depth(Depth)) mirror (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side stalls at random, except during the calm stretch.
   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 24);
   end

   // Watchdog: too many cycles in a row with no word moving on either side.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("FAIL double_ended_queue_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one request word, with a random idle gap in front of it.
   task automatic send_word(input action_type act, input logic signed [DataW-1:0] value);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.data_in <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Holds the request side idle until every result word has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly random values, with the extremes mixed in now and then.
   function automatic logic signed [DataW-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int push_lean;
      int run_left;
      action_type act;

      calm            <= 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= ACT_PUSH_FRONT;
      req_bus.data_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Pops on the empty queue are refused.
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);

      // Fill to the top from both ends; the first front push wraps the head.
      send_word(ACT_PUSH_FRONT, 32'sh7fff_ffff);
      send_word(ACT_PUSH_BACK, 32'sh8000_0000);
      send_word(ACT_PUSH_FRONT, -32'sd1);
      send_word(ACT_PUSH_BACK, '0);
      for (int i = 0; i < 12; i++) begin
         send_word(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom);
      end

      // Pushes on the full queue are refused at either end.
      send_word(ACT_PUSH_FRONT, $urandom);
      send_word(ACT_PUSH_BACK, $urandom);

      // Pops from both ends.
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);

      wait_for_drain();

      // Random runs that lean toward pushing, popping, or neither, so the
      // queue keeps hitting both the full and the empty corner.
      push_lean = 50;
      run_left  = 0;
      for (int n = 0; n < RandomWords; n++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 2))
               0:       push_lean = 80;
               1:       push_lean = 20;
               default: push_lean = 50;
            endcase
            run_left = $urandom_range(20, 60);
         end
         run_left--;
         if (n == 400) calm <= 1'b1;
         if (n == 700) calm <= 1'b0;
         if (n == 1000) wait_for_drain();
         if ($urandom_range(0, 99) < push_lean) begin
            act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
         end else begin
            act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
         end
         send_word(act, pick_value());
      end

      // Let every result come home, then keep watching for stray words.
      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS double_ended_queue_core");
      end else begin
         $display("FAIL double_ended_queue_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/deq_pkg.sv
design/deq_req_if.sv
design/deq_rsp_if.sv
design/deq_cell.sv
design/deq_chain.sv
design/double_ended_queue_core.sv
dv/deq_mirror.sv
dv/double_ended_queue_core_test.sv
